>>> hdl/teab_pkg.sv
// ----------------------------------------------------------------------------
// teab_pkg
// Shared constants for the triangle edge adjacency builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package teab_pkg;

  // Default sizing
  localparam int MAX_FACES_DEF   = 64;
  localparam int VERT_BITS_DEF   = 16;

  // Fixed field widths of the ports
  localparam int VERT_IN_W  = 16;
  localparam int FACE_NUM_W = 6;

  // Edge codes within a face
  typedef logic [1:0] edge_t;
  localparam edge_t EDGE_AB = 2'd0;
  localparam edge_t EDGE_BC = 2'd1;
  localparam edge_t EDGE_CA = 2'd2;

endpackage : teab_pkg

`default_nettype wire

>>> hdl/triangle_edge_adjacency_builder_top.sv
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_builder_top
// Stores triangles, pairs shared edges greedily after the last one and then
// emits the three neighbouring faces of every stored face.
// ----------------------------------------------------------------------------
// Loading: one triangle word per cycle while idle, no result until the last face word.
// Pairing: per face the vertex read, the capture and the edge steps; each unlinked edge
//   scans the candidates, skipping full or own faces and reading and comparing the others
//   (one vertex read port, one comparator), then re-enters the edge step; a match adds a join.
// Output: each result word takes a link read step and a load step; the consumer can stall it.
// Reset clears face count, link valid bits and output valid; no memory sweep.
`timescale 1ns / 1ps
`default_nettype none

module triangle_edge_adjacency_builder_top
  import teab_pkg::*;
#(
  parameter int MAX_FACES         = MAX_FACES_DEF,
  parameter int VERTEX_INDEX_BITS = VERT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VERT_IN_W-1:0]  vertex_a,
  input  wire logic [VERT_IN_W-1:0]  vertex_b,
  input  wire logic [VERT_IN_W-1:0]  vertex_c,
  input  wire logic                  last_face,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FACE_NUM_W-1:0]      face_number,
  output logic [FACE_NUM_W-1:0]      neighbour_ab,
  output logic [FACE_NUM_W-1:0]      neighbour_bc,
  output logic [FACE_NUM_W-1:0]      neighbour_ca,
  output logic                       last_result
);

  localparam int FB = $clog2(MAX_FACES);
  localparam int CW = $clog2(MAX_FACES + 1);
  localparam int VB = VERTEX_INDEX_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FLOAD = 9'b000000010,
    S_FCAP  = 9'b000000100,
    S_EDGE  = 9'b000001000,
    S_GREAD = 9'b000010000,
    S_GCMP  = 9'b000100000,
    S_JOIN2 = 9'b001000000,
    S_OREAD = 9'b010000000,
    S_OLOAD = 9'b100000000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [FB-1:0]   f;
  logic [FB-1:0]   g;
  edge_t           e;
  edge_t           ge_r;
  logic [VB-1:0]   va, vb, vc;
  logic [2:0]      link_set [MAX_FACES];

  // Memories
  logic [3*VB-1:0] vmem [MAX_FACES];
  logic [3*VB-1:0] vrd;
  logic [FB-1:0]   lmem_ab [MAX_FACES];
  logic [FB-1:0]   lmem_bc [MAX_FACES];
  logic [FB-1:0]   lmem_ca [MAX_FACES];
  logic [FB-1:0]   lrd_ab, lrd_bc, lrd_ca;

  logic            in_acc;
  logic            store;
  logic [FB-1:0]   vaddr;
  logic            f_last, g_last;
  logic [2:0]      lg;
  logic [VB-1:0]   p1, p2, p3, eu, ev;
  logic            skip_g;
  logic            c1, c2, c3;
  logic            match;
  edge_t           ge;
  logic            lw_en;
  edge_t           lw_edge;
  logic [FB-1:0]   lw_addr;
  logic [FB-1:0]   lw_data;
  logic            out_load;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign store    = in_acc && (count < CW'(MAX_FACES));
  assign f_last   = ((CW'(f) + CW'(1)) == count);
  assign g_last   = ((CW'(g) + CW'(1)) == count);
  assign vaddr    = (state == S_FLOAD) ? f : g;
  assign out_load = (state == S_OLOAD) && (!out_valid || out_ready);

  // Vertex store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store) begin
      vmem[count[FB-1:0]] <= {VB'(vertex_c), VB'(vertex_b), VB'(vertex_a)};
    end
    vrd <= vmem[vaddr];
  end

  // Candidate face compare
  always_comb begin
    lg = link_set[g];
    p1 = vrd[VB-1:0];
    p2 = vrd[2*VB-1:VB];
    p3 = vrd[3*VB-1:2*VB];
    unique case (e)
      EDGE_AB: begin eu = va; ev = vb; end
      EDGE_BC: begin eu = vb; ev = vc; end
      default: begin eu = va; ev = vc; end
    endcase
    skip_g = (g == f) || (&lg);
    c1 = (!lg[0] || !lg[2]) && (eu == p1);
    c2 = !c1 && (!lg[0] || !lg[1]) && (eu == p2);
    c3 = !c1 && !c2 && (!lg[2] || !lg[1]) && (eu == p3);
    match = 1'b0;
    ge    = EDGE_AB;
    priority if (c1) begin
      if (!lg[0] && ev == p2) begin
        match = 1'b1; ge = EDGE_AB;
      end else if (!lg[2] && ev == p3) begin
        match = 1'b1; ge = EDGE_CA;
      end
    end else if (c2) begin
      if (!lg[0] && ev == p1) begin
        match = 1'b1; ge = EDGE_AB;
      end else if (!lg[1] && ev == p3) begin
        match = 1'b1; ge = EDGE_BC;
      end
    end else if (c3) begin
      if (!lg[2] && ev == p1) begin
        match = 1'b1; ge = EDGE_CA;
      end else if (!lg[1] && ev == p2) begin
        match = 1'b1; ge = EDGE_BC;
      end
    end else begin
      // no vertex of the candidate touches an open edge
      match = 1'b0;
    end
  end

  // Link store write port: own side on join or self link, partner side after
  always_comb begin
    lw_en   = 1'b0;
    lw_edge = e;
    lw_addr = f;
    lw_data = f;
    unique case (state)
      S_GREAD: lw_en = skip_g && g_last;
      S_GCMP: begin
        lw_en   = match || g_last;
        lw_data = match ? g : f;
      end
      S_JOIN2: begin
        lw_en   = 1'b1;
        lw_edge = ge_r;
        lw_addr = g;
        lw_data = f;
      end
      default: lw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en && lw_edge == EDGE_AB) lmem_ab[lw_addr] <= lw_data;
    if (lw_en && lw_edge == EDGE_BC) lmem_bc[lw_addr] <= lw_data;
    if (lw_en && lw_edge == EDGE_CA) lmem_ca[lw_addr] <= lw_data;
    lrd_ab <= lmem_ab[f];
    lrd_bc <= lmem_bc[f];
    lrd_ca <= lmem_ca[f];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      f     <= '0;
      g     <= '0;
      e     <= EDGE_AB;
      ge_r  <= EDGE_AB;
      for (int i = 0; i < MAX_FACES; i++) link_set[i] <= 3'b000;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (store) count <= count + CW'(1);
          if (in_acc && last_face) begin
            f     <= '0;
            state <= S_FLOAD;
          end
        end
        S_FLOAD: state <= S_FCAP;
        S_FCAP: begin
          va    <= vrd[VB-1:0];
          vb    <= vrd[2*VB-1:VB];
          vc    <= vrd[3*VB-1:2*VB];
          e     <= EDGE_AB;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (!link_set[f][e]) begin
            g     <= '0;
            state <= S_GREAD;
          end else if (e != EDGE_CA) begin
            e <= e + 2'd1;
          end else if (f_last) begin
            f     <= '0;
            state <= S_OREAD;
          end else begin
            f     <= f + FB'(1);
            state <= S_FLOAD;
          end
        end
        S_GREAD: begin
          if (!skip_g) begin
            state <= S_GCMP;
          end else if (!g_last) begin
            g <= g + FB'(1);
          end else begin
            // no partner: link to own face
            link_set[f][e] <= 1'b1;
            state          <= S_EDGE;
          end
        end
        S_GCMP: begin
          if (match) begin
            link_set[f][e]  <= 1'b1;
            link_set[g][ge] <= 1'b1;
            ge_r            <= ge;
            state           <= S_JOIN2;
          end else if (!g_last) begin
            g     <= g + FB'(1);
            state <= S_GREAD;
          end else begin
            link_set[f][e] <= 1'b1;
            state          <= S_EDGE;
          end
        end
        S_JOIN2: state <= S_EDGE;
        S_OREAD: state <= S_OLOAD;
        S_OLOAD: begin
          if (out_load) begin
            if (f_last) begin
              count <= '0;
              for (int i = 0; i < MAX_FACES; i++) link_set[i] <= 3'b000;
              state <= S_IDLE;
            end else begin
              f     <= f + FB'(1);
              state <= S_OREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      face_number  <= FACE_NUM_W'(f);
      neighbour_ab <= FACE_NUM_W'(lrd_ab);
      neighbour_bc <= FACE_NUM_W'(lrd_bc);
      neighbour_ca <= FACE_NUM_W'(lrd_ca);
      last_result  <= f_last;
    end
  end

endmodule : triangle_edge_adjacency_builder_top

`default_nettype wire
